/* hw/rtl/iolj_pkg.sv */
// Package for the interval overlap join unit.
// Field widths, operation and status codes, and the control/status structs.
// No dependencies.
package iolj_pkg;

  // Payload field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SEG_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned QIDX_W   = 16;
  localparam int unsigned RIDX_W   = 6;

  // Operation codes; code 3 is ignored
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // input item accepted this cycle
    logic scan_run;  // scan advances this cycle
    logic flush;     // write the final query result
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic scan_start;  // pending input is a query over a non-empty store
    logic rd_valid;    // an entry is under compare
    logic rd_last;     // the entry under compare is the last stored one
    logic hit;         // the entry under compare overlaps the query
    logic pend_valid;  // a match is held back until the next one is known
  } dp_status_t;

endpackage

/* hw/rtl/iolj_if.sv */
// Valid/ready channel interfaces for the interval overlap join unit.
// Depends on iolj_pkg.
interface iolj_in_if import iolj_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [SEG_W-1:0] seg_left;
  logic signed [SEG_W-1:0] seg_right;

  modport source (output valid, operation, seg_left, seg_right, input ready);
  modport sink   (input valid, operation, seg_left, seg_right, output ready);
endinterface

interface iolj_out_if import iolj_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [QIDX_W-1:0]   query_index;
  logic [RIDX_W-1:0]   ref_index;
  logic                last;

  modport source (output valid, status, query_index, ref_index, last, input ready);
  modport sink   (input valid, status, query_index, ref_index, last, output ready);
endinterface

/* hw/rtl/interval_overlap_join_unit.sv */
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    operation, seg_left, seg_right
// out_o     out  valid/ready    status, query_index, ref_index, last
//
// A query scans the stored references, reading one store entry per cycle, unless
// the scan is held, through the single RAM read port.
// A backpressured output holds the scan when a second match is found.
// Reset empties the store and the query numbering; store contents are not cleared.
//
// Top level of the interval overlap join unit.
// Depends on iolj_pkg, iolj_if, iolj_ram, iolj_ctrl and iolj_dp.
module interval_overlap_join_unit import iolj_pkg::*; #(
  parameter int unsigned REF_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iolj_in_if.sink   in_i,
  iolj_out_if.source out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequencing
  iolj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store, compare and result register
  iolj_dp #(
    .REF_DEPTH (REF_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_op_i           (in_i.operation),
    .in_left_i         (in_i.seg_left),
    .in_right_i        (in_i.seg_right),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_status_o      (out_o.status),
    .out_query_index_o (out_o.query_index),
    .out_ref_index_o   (out_o.ref_index),
    .out_last_o        (out_o.last)
  );

endmodule

/* hw/rtl/iolj_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iolj_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/iolj_ctrl.sv */
// Controller for the interval overlap join unit: idle, scan and flush phases.
// Depends on iolj_pkg.
module iolj_ctrl import iolj_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   stall;

  // Hold the scan when a second match needs the output register and it is full
  assign stall = sts_i.rd_valid && sts_i.hit && sts_i.pend_valid && !sts_i.out_free;

  // Decode commands and next state
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.take     = 1'b0;
    cmd_o.scan_run = 1'b0;
    cmd_o.flush    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        cmd_o.take = in_valid_i && sts_i.out_free;
        if (cmd_o.take && sts_i.scan_start) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = !stall;
        if (!stall && sts_i.rd_valid && sts_i.rd_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Accept items only between queries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("input ready outside idle");

  // Final query result only goes into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flush |-> sts_i.out_free)
    else $error("flush into a busy output register");

  // A query over a non-empty store always enters the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take && sts_i.scan_start |=> state_q == S_SCAN)
    else $error("query did not start a scan");

endmodule

/* hw/rtl/iolj_dp.sv */
// Datapath for the interval overlap join unit: reference store, counters,
// overlap compare, held-back match and output register.
// Depends on iolj_pkg and iolj_ram.
module iolj_dp import iolj_pkg::*; #(
  parameter int unsigned REF_DEPTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [OP_W-1:0]         in_op_i,
  input  logic signed [SEG_W-1:0] in_left_i,
  input  logic signed [SEG_W-1:0] in_right_i,
  input  ctrl_cmd_t               cmd_i,
  output dp_status_t              sts_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [STATUS_W-1:0]     out_status_o,
  output logic [QIDX_W-1:0]       out_query_index_o,
  output logic [RIDX_W-1:0]       out_ref_index_o,
  output logic                    out_last_o
);

  localparam int unsigned IdxW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(REF_DEPTH + 1);

  logic [CntW-1:0]         ref_count_q, ref_count_d;
  logic [QIDX_W-1:0]       query_count_q, query_count_d;
  logic [QIDX_W-1:0]       qidx_q, qidx_d;
  logic signed [SEG_W-1:0] q_left_q, q_right_q;
  logic [CntW-1:0]         ptr_q, ptr_d;
  logic                    rd_valid_q, rd_valid_d;
  logic [IdxW-1:0]         rd_idx_q, rd_idx_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]         pend_idx_q, pend_idx_d;

  logic                    out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]     out_status_q, out_status_d;
  logic [QIDX_W-1:0]       out_qidx_q, out_qidx_d;
  logic [RIDX_W-1:0]       out_ridx_q, out_ridx_d;
  logic                    out_last_q, out_last_d;
  logic                    out_load;

  logic                    full, empty, issue, hit, out_free, push_match;
  logic                    ram_we, ram_re;
  logic [2*SEG_W-1:0]      ram_rdata;
  logic signed [SEG_W-1:0] rd_left, rd_right;

  assign full     = (ref_count_q == CntW'(REF_DEPTH));
  assign empty    = (ref_count_q == '0);
  assign issue    = (ptr_q < ref_count_q);
  assign out_free = !out_valid_q || out_ready_i;

  // Store: left end in the upper half, right end in the lower half
  assign ram_we = cmd_i.take && (in_op_i == OP_LOAD) && !full;
  assign ram_re = cmd_i.scan_run && issue;

  iolj_ram #(
    .WIDTH (2 * SEG_W),
    .DEPTH (REF_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ref_count_q[IdxW-1:0]),
    .wdata_i ({in_left_i, in_right_i}),
    .re_i    (ram_re),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Strict overlap compare, signed
  assign rd_left    = $signed(ram_rdata[2*SEG_W-1:SEG_W]);
  assign rd_right   = $signed(ram_rdata[SEG_W-1:0]);
  assign hit        = (rd_right > q_left_q) && (rd_left < q_right_q);
  assign push_match = cmd_i.scan_run && rd_valid_q && hit && pend_valid_q;

  // Status to the controller
  assign sts_o.out_free   = out_free;
  assign sts_o.scan_start = (in_op_i == OP_QUERY) && !empty;
  assign sts_o.rd_valid   = rd_valid_q;
  assign sts_o.rd_last    = (CntW'(rd_idx_q) + CntW'(1)) == ref_count_q;
  assign sts_o.hit        = hit;
  assign sts_o.pend_valid = pend_valid_q;

  // Counters, query latch and scan pointer
  always_comb begin
    ref_count_d   = ref_count_q;
    query_count_d = query_count_q;
    qidx_d        = qidx_q;
    ptr_d         = ptr_q;
    rd_valid_d    = rd_valid_q;
    rd_idx_d      = rd_idx_q;
    pend_valid_d  = pend_valid_q;
    pend_idx_d    = pend_idx_q;
    if (cmd_i.take) begin
      ptr_d        = '0;
      rd_valid_d   = 1'b0;
      pend_valid_d = 1'b0;
      case (in_op_i)
        OP_CLEAR: begin
          ref_count_d   = '0;
          query_count_d = '0;
        end
        OP_LOAD: begin
          if (!full) begin
            ref_count_d = ref_count_q + CntW'(1);
          end
        end
        OP_QUERY: begin
          qidx_d = query_count_q;
          if (query_count_q != '1) begin
            query_count_d = query_count_q + QIDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.scan_run) begin
      // Advance the read and keep the newest match back
      rd_valid_d = issue;
      rd_idx_d   = ptr_q[IdxW-1:0];
      if (issue) begin
        ptr_d = ptr_q + CntW'(1);
      end
      if (rd_valid_q && hit) begin
        pend_valid_d = 1'b1;
        pend_idx_d   = rd_idx_q;
      end
    end else if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
      rd_valid_d   = 1'b0;
    end
  end

  // Output register load
  always_comb begin
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_qidx_d   = out_qidx_q;
    out_ridx_d   = out_ridx_q;
    out_last_d   = out_last_q;
    if (cmd_i.take) begin
      case (in_op_i)
        OP_CLEAR: begin
          out_load     = 1'b1;
          out_status_d = ST_CLEARED;
          out_qidx_d   = '0;
          out_ridx_d   = '0;
          out_last_d   = 1'b1;
        end
        OP_LOAD: begin
          out_load     = 1'b1;
          out_status_d = full ? ST_FULL : ST_LOADED;
          out_qidx_d   = '0;
          out_ridx_d   = full ? '0 : RIDX_W'(ref_count_q[IdxW-1:0]);
          out_last_d   = 1'b1;
        end
        OP_QUERY: begin
          if (empty) begin
            out_load     = 1'b1;
            out_status_d = ST_NOMATCH;
            out_qidx_d   = query_count_q;
            out_ridx_d   = '0;
            out_last_d   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (push_match) begin
      out_load     = 1'b1;
      out_status_d = ST_MATCH;
      out_qidx_d   = qidx_q;
      out_ridx_d   = RIDX_W'(pend_idx_q);
      out_last_d   = 1'b0;
    end else if (cmd_i.flush) begin
      out_load     = 1'b1;
      out_status_d = pend_valid_q ? ST_MATCH : ST_NOMATCH;
      out_qidx_d   = qidx_q;
      out_ridx_d   = pend_valid_q ? RIDX_W'(pend_idx_q) : '0;
      out_last_d   = 1'b1;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_count_q   <= '0;
      query_count_q <= '0;
      ptr_q         <= '0;
      rd_valid_q    <= 1'b0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      ref_count_q   <= ref_count_d;
      query_count_q <= query_count_d;
      ptr_q         <= ptr_d;
      rd_valid_q    <= rd_valid_d;
      pend_valid_q  <= pend_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    qidx_q       <= qidx_d;
    rd_idx_q     <= rd_idx_d;
    pend_idx_q   <= pend_idx_d;
    out_status_q <= out_status_d;
    out_qidx_q   <= out_qidx_d;
    out_ridx_q   <= out_ridx_d;
    out_last_q   <= out_last_d;
    if (cmd_i.take && (in_op_i == OP_QUERY)) begin
      q_left_q  <= in_left_i;
      q_right_q <= in_right_i;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_query_index_o = out_qidx_q;
  assign out_ref_index_o   = out_ridx_q;
  assign out_last_o        = out_last_q;

  // Never overwrite a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !out_load)
    else $error("output register overwritten");

  // Fill count stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_count_q <= CntW'(REF_DEPTH))
    else $error("reference count beyond depth");

  // Only loaded entries are compared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> CntW'(rd_idx_q) < ref_count_q)
    else $error("compare of an unloaded entry");

endmodule

/* tb/iolj_join_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the interval overlap join unit: watches both channels,
// predicts the result items of every accepted item and compares them in order.
// Depends on iolj_pkg and iolj_if.
module iolj_join_checker import iolj_pkg::*; #(
  parameter int unsigned REF_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iolj_in_if          in_i,
  iolj_out_if         out_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned item_cnt_o,
  output int unsigned result_cnt_o,
  output int unsigned match_cnt_o
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QIDX_W-1:0]   query_index;
    logic [RIDX_W-1:0]   ref_index;
    logic                last;
  } join_res_t;

  // Shadow copy of the reference store and the query numbering
  logic signed [SEG_W-1:0] store_left  [REF_DEPTH];
  logic signed [SEG_W-1:0] store_right [REF_DEPTH];
  int unsigned             stored_n;
  logic [QIDX_W-1:0]       query_num;

  join_res_t   pending_res_q[$];
  join_res_t   want;
  int unsigned mismatches;
  int unsigned items_seen;
  int unsigned results_seen;
  int unsigned matches_seen;

  // Append one expected result item to the tail of the queue
  function automatic void expect_result(input logic [STATUS_W-1:0] status,
                                        input logic [QIDX_W-1:0]   qidx,
                                        input logic [RIDX_W-1:0]   ridx,
                                        input logic                last_flag);
    join_res_t res;
    res.status      = status;
    res.query_index = qidx;
    res.ref_index   = ridx;
    res.last        = last_flag;
    pending_res_q.insert(pending_res_q.size(), res);
  endfunction

  // Work out the result items of one accepted item and queue them
  function automatic void predict_join(input logic [OP_W-1:0] op,
                                       input logic signed [SEG_W-1:0] q_left,
                                       input logic signed [SEG_W-1:0] q_right);
    int unsigned       hits[$];
    logic [QIDX_W-1:0] qidx;
    case (op)
      OP_CLEAR: begin
        stored_n  = 0;
        query_num = '0;
        expect_result(ST_CLEARED, '0, '0, 1'b1);
      end
      OP_LOAD: begin
        if (stored_n >= REF_DEPTH) begin
          expect_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          store_left[stored_n]  = q_left;
          store_right[stored_n] = q_right;
          expect_result(ST_LOADED, '0, RIDX_W'(stored_n), 1'b1);
          stored_n++;
        end
      end
      OP_QUERY: begin
        qidx = query_num;
        // numbering sticks at its top value
        if (query_num != '1) query_num = query_num + 1'b1;
        for (int unsigned i = 0; i < stored_n; i++) begin
          if (store_right[i] > q_left && store_left[i] < q_right) hits.insert(hits.size(), i);
        end
        if (hits.size() == 0) begin
          expect_result(ST_NOMATCH, qidx, '0, 1'b1);
        end else begin
          foreach (hits[k]) begin
            expect_result(ST_MATCH, qidx, RIDX_W'(hits[k]), 1'(k == hits.size() - 1));
          end
        end
      end
      default: ;  // ignored code: no result, state unchanged
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_res_q.delete();
      stored_n     = 0;
      query_num    = '0;
      mismatches   = 0;
      items_seen   = 0;
      results_seen = 0;
      matches_seen = 0;
      fail_cnt_o   <= 0;
      pending_o    <= 0;
      item_cnt_o   <= 0;
      result_cnt_o <= 0;
      match_cnt_o  <= 0;
    end else begin
      // Predict from every accepted input item
      if (in_i.valid && in_i.ready) begin
        predict_join(in_i.operation, in_i.seg_left, in_i.seg_right);
        items_seen++;
      end
      // Compare every accepted result item with the oldest expectation
      if (out_i.valid && out_i.ready) begin
        results_seen++;
        if (out_i.status == ST_MATCH) matches_seen++;
        if (pending_res_q.size() == 0) begin
          $error("unexpected result: status %0d query_index %0d ref_index %0d last %0b",
                 out_i.status, out_i.query_index, out_i.ref_index, out_i.last);
          mismatches++;
        end else begin
          want = pending_res_q.pop_front();
          if (out_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_i.status);
            mismatches++;
          end
          if (out_i.query_index !== want.query_index) begin
            $error("query_index: expected %0d, got %0d", want.query_index,
                   out_i.query_index);
            mismatches++;
          end
          if (out_i.ref_index !== want.ref_index) begin
            $error("ref_index: expected %0d, got %0d", want.ref_index, out_i.ref_index);
            mismatches++;
          end
          if (out_i.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_i.last);
            mismatches++;
          end
        end
      end
      fail_cnt_o   <= mismatches;
      pending_o    <= pending_res_q.size();
      item_cnt_o   <= items_seen;
      result_cnt_o <= results_seen;
      match_cnt_o  <= matches_seen;
    end
  end

endmodule

/* tb/tb_interval_overlap_join_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the interval overlap join unit: clock, reset, stimulus,
// output stalls, watchdog and verdict. Depends on iolj_pkg, iolj_if and iolj_join_checker.
module tb_interval_overlap_join_unit;
  import iolj_pkg::*;

  localparam int unsigned REF_DEPTH      = 32;
  localparam int unsigned RAND_ITEMS     = 360;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 2 * REF_DEPTH + 10;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  localparam logic signed [SEG_W-1:0] SEG_MIN = 32'sh8000_0000;
  localparam logic signed [SEG_W-1:0] SEG_MAX = 32'sh7fff_ffff;

  logic clk_i;
  logic rst_ni;

  iolj_in_if  in_if ();
  iolj_out_if out_if ();

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned item_cnt;
  int unsigned result_cnt;
  int unsigned match_cnt;

  bit tx_steady;
  bit rx_steady;
  bit rx_hold_req;

  interval_overlap_join_unit #(.REF_DEPTH(REF_DEPTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  iolj_join_checker #(.REF_DEPTH(REF_DEPTH)) join_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending_cnt),
    .item_cnt_o   (item_cnt),
    .result_cnt_o (result_cnt),
    .match_cnt_o  (match_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Coordinates: a narrow cluster for overlaps, full random words, extremes
  function automatic logic signed [SEG_W-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return int'($urandom_range(0, 240)) - 120;
    if (r < 80) return $urandom;
    case ($urandom_range(0, 5))
      0: return SEG_MIN;
      1: return SEG_MIN + 1;
      2: return SEG_MAX;
      3: return SEG_MAX - 1;
      4: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic rand_span(output logic signed [SEG_W-1:0] l,
                           output logic signed [SEG_W-1:0] r);
    l = rand_coord();
    // short spans mostly; the sum may wrap and give an inverted interval
    if ($urandom_range(0, 9) < 8) r = l + $urandom_range(0, 60);
    else r = rand_coord();
  endtask

  // Offer one item and hold it until accepted
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [SEG_W-1:0] l,
                           input logic signed [SEG_W-1:0] r);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.seg_left  <= l;
    in_if.seg_right <= r;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Drop valid and hold until every expected result has come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 19) == 0) send_item(OP_IGNORED, rand_coord(), rand_coord());
  endtask

  // Receiver: random stalls, steady stretches, one long hold on request
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else if (!rx_steady) begin
        stall = pick_gap();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $error("watchdog: no item accepted for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_cnt);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic signed [SEG_W-1:0] l;
    logic signed [SEG_W-1:0] r;
    int unsigned             rand_items;
    int unsigned             seq_no;
    int unsigned             n_loads;
    int unsigned             pick;

    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_CLEAR;
    in_if.seg_left  <= '0;
    in_if.seg_right <= '0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    rx_hold_req = 1'b0;
    rand_items  = 0;
    seq_no      = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, ignored code, edge-touching, empty and inverted
    // intervals, full-range extremes, then a clear that restarts numbering
    send_item(OP_QUERY, SEG_MIN, SEG_MAX);
    send_item(OP_IGNORED, SEG_MAX, SEG_MIN);
    send_item(OP_LOAD, SEG_MIN, SEG_MAX);
    send_item(OP_LOAD, 0, 10);
    send_item(OP_LOAD, 10, 20);
    send_item(OP_LOAD, 5, 5);
    send_item(OP_LOAD, 20, 10);
    send_item(OP_LOAD, -100, -50);
    send_item(OP_QUERY, 10, 10);
    send_item(OP_QUERY, 9, 11);
    send_item(OP_QUERY, SEG_MIN, SEG_MIN + 1);
    send_item(OP_QUERY, SEG_MAX - 1, SEG_MAX);
    send_item(OP_QUERY, SEG_MIN, SEG_MAX);
    send_item(OP_QUERY, 20, 10);
    send_item(OP_QUERY, 0, 10);
    send_item(OP_QUERY, -50, 0);
    send_item(OP_IGNORED, '1, '1);
    send_item(OP_CLEAR, SEG_MAX, SEG_MIN);
    send_item(OP_QUERY, SEG_MIN, SEG_MAX);
    send_item(OP_LOAD, SEG_MAX, SEG_MIN);
    send_item(OP_QUERY, SEG_MAX, SEG_MIN);

    // Random: sequences of optional clear, loads (some past full), queries
    while (rand_items < RAND_ITEMS) begin
      seq_no++;
      tx_steady = (seq_no % 5 == 0);
      rx_steady = (seq_no % 7 == 3);
      if (seq_no == 6) rx_hold_req = 1'b1;
      if (seq_no == 12) wait_drained();
      if ($urandom_range(0, 9) < 3) begin
        send_item(OP_CLEAR, rand_coord(), rand_coord());
        rand_items++;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) n_loads = $urandom_range(1, 10);
      else if (pick < 9) n_loads = REF_DEPTH + $urandom_range(1, 3);
      else n_loads = 0;
      repeat (n_loads) begin
        rand_span(l, r);
        send_item(OP_LOAD, l, r);
        rand_items++;
        maybe_noise();
      end
      repeat ($urandom_range(1, 8)) begin
        rand_span(l, r);
        send_item(OP_QUERY, l, r);
        rand_items++;
        maybe_noise();
      end
    end

    // Back-to-back tail, then check that a clear restarts the numbering
    wait_drained();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_LOAD, -10, 10);
    send_item(OP_LOAD, 5, 50);
    repeat (4) begin
      rand_span(l, r);
      send_item(OP_QUERY, l, r);
    end
    send_item(OP_QUERY, 0, 6);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_QUERY, 0, 1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_cnt != 0) $error("%0d expected results never arrived", pending_cnt);
    $display("Run covered %0d items and %0d results, %0d of them overlap matches,",
             item_cnt, result_cnt, match_cnt);
    $display("with full-store rejects, a long output hold and clears between queries.");
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
